// ----- design/ttw_pkg.sv -----
// Shared types and constants for the text terminal writer.
// No dependencies; imported by every module of the block.
package ttw_pkg;

   // One grid cell: character byte, foreground and background color.
   typedef struct packed {
      logic [7:0] ch;
      logic [2:0] fg;
      logic [2:0] bg;
   } cell_type;

   // Operation codes on the request channel
   localparam logic [2:0] OP_PUT    = 3'd0;
   localparam logic [2:0] OP_CURSOR = 3'd1;
   localparam logic [2:0] OP_COLOR  = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // Control characters interpreted by put char
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   // Register indexes on the configuration port
   localparam logic REG_BG_COLOR = 1'b0;

   localparam logic [2:0] FG_RESET = 3'd7;

endpackage

// ----- design/ttw_grid_ram.sv -----
// Cell memory of the terminal grid: one write port, one read port,
// read data registered. Depends on ttw_pkg for the cell type.
module ttw_grid_ram #(
   parameter int DEPTH  = 1590,
   parameter int ADDR_W = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  ttw_pkg::cell_type   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output ttw_pkg::cell_type   rd_data
);
   import ttw_pkg::*;

   cell_type mem_q [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_q[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/text_terminal_writer_unit.sv -----
// Top level of the text terminal writer: cursor, colors, command decode,
// grid sweep sequencer and the configuration port. Depends on ttw_pkg and
// instantiates ttw_grid_ram for the character/color grid.
//
//   channel | direction | handshake            | carries
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | opcode, char code, color, col, row
//   rsp     | out       | rsp_valid/rsp_stall  | cell char/fg/bg, cursor col/row
//   csr     | in/out    | APB psel/penable     | background color register
//
// Put char (no scroll), set cursor and set color load their result when
// taken; read cell loads it in ST_READ, after the registered grid memory read.
// Clear, and a put char that scrolls, then hold the block in ST_SWEEP and
// ST_DRAIN: one memory entry is read and written back per cycle through the
// single RAM port pair. After reset the grid is swept to zero; items are held
// off meanwhile, configuration writes are taken as always. A new item is
// taken when idle and the result register is empty or drains that cycle.
module text_terminal_writer_unit #(
   parameter int COLS = 53,
   parameter int ROWS = 30
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_opcode,
   input  logic [7:0]                 req_char_code,
   input  logic [2:0]                 req_color,
   input  logic [$clog2(COLS)-1:0]    req_col,
   input  logic [$clog2(ROWS)-1:0]    req_row,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_cell_char,
   output logic [2:0]                 rsp_cell_fg,
   output logic [2:0]                 rsp_cell_bg,
   output logic [$clog2(COLS)-1:0]    rsp_cursor_col,
   output logic [$clog2(ROWS)-1:0]    rsp_cursor_row,

   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import ttw_pkg::*;

   localparam int COL_W     = $clog2(COLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int CELLS     = COLS * ROWS;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int LAST_BASE = CELLS - COLS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      MODE_INIT,
      MODE_SCROLL,
      MODE_CLEAR
   } mode_type;

   // Control state
   state_type          state_ff,    state_in;
   mode_type           mode_ff,     mode_in;
   logic [CELL_W-1:0]  rd_idx_ff,   rd_idx_in;
   logic               wr_pend_ff,  wr_pend_in;
   logic [COL_W-1:0]   cursor_x_ff, cursor_x_in;
   logic [ROW_W-1:0]   cursor_y_ff, cursor_y_in;
   logic [2:0]         cur_fg_ff,   cur_fg_in;
   logic [2:0]         bg_color_ff, bg_color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               read_hit_ff, read_hit_in;

   // Payload registers
   logic [CELL_W-1:0]  wr_idx_ff,   wr_idx_in;
   logic               wr_last_ff,  wr_last_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic [2:0]         rsp_fg_ff,   rsp_fg_in;
   logic [2:0]         rsp_bg_ff,   rsp_bg_in;
   logic [COL_W-1:0]   rsp_col_ff,  rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff,  rsp_row_in;

   // Memory ports
   logic               ram_wr_en;
   logic [CELL_W-1:0]  ram_wr_addr;
   cell_type           ram_wr_data;
   logic [CELL_W-1:0]  ram_rd_addr;
   cell_type           ram_rd_data;

   logic               accept;
   logic               rsp_load;
   logic               csr_write;
   logic [CELL_W-1:0]  cursor_addr;
   logic [CELL_W-1:0]  req_addr;
   logic               req_in_range;

   ttw_grid_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (CELL_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Take a new item only when idle and the result register is free.
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   // Configuration port: always ready, one register at index 0.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_BG_COLOR) ? {29'd0, bg_color_ff} : 32'd0;

   // Cell addresses: cursor cell for put char, requested cell for read.
   assign cursor_addr  = CELL_W'(32'(cursor_y_ff) * COLS + 32'(cursor_x_ff));
   assign req_in_range = (32'(req_col) < COLS) && (32'(req_row) < ROWS);
   assign req_addr     = req_in_range ?
                         CELL_W'(32'(req_row) * COLS + 32'(req_col)) : '0;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rd_idx_in    = rd_idx_ff;
      wr_pend_in   = 1'b0;
      wr_idx_in    = rd_idx_ff;
      wr_last_in   = (32'(rd_idx_ff) >= LAST_BASE);
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      cur_fg_in    = cur_fg_ff;
      bg_color_in  = bg_color_ff;
      read_hit_in  = read_hit_ff;
      rsp_load     = 1'b0;
      rsp_char_in  = 8'd0;
      rsp_fg_in    = 3'd0;
      rsp_bg_in    = 3'd0;
      ram_rd_addr  = req_addr;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cursor_addr;
      ram_wr_data  = '{ch: req_char_code, fg: cur_fg_ff, bg: bg_color_ff};

      if (csr_write && (csr_paddr[2] == REG_BG_COLOR)) begin
         bg_color_in = csr_pwdata[2:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_PUT: begin
                     priority if (req_char_code == CH_NEWLINE) begin
                        if (32'(cursor_y_ff) < ROWS - 1) begin
                           cursor_y_in = cursor_y_ff + 1'b1;
                        end else begin
                           state_in = ST_SWEEP;
                           mode_in  = MODE_SCROLL;
                        end
                     end else if (req_char_code == CH_RETURN) begin
                        cursor_x_in = '0;
                     end else if (req_char_code == CH_BACKSPACE) begin
                        if (cursor_x_ff == '0) begin
                           cursor_x_in = COL_W'(COLS - 1);
                           if (cursor_y_ff != '0) begin
                              cursor_y_in = cursor_y_ff - 1'b1;
                           end
                        end else begin
                           cursor_x_in = cursor_x_ff - 1'b1;
                        end
                     end else begin
                        // Store the character, then advance with wrap.
                        ram_wr_en = 1'b1;
                        if (32'(cursor_x_ff) == COLS - 1) begin
                           cursor_x_in = '0;
                           if (32'(cursor_y_ff) < ROWS - 1) begin
                              cursor_y_in = cursor_y_ff + 1'b1;
                           end else begin
                              state_in = ST_SWEEP;
                              mode_in  = MODE_SCROLL;
                           end
                        end else begin
                           cursor_x_in = cursor_x_ff + 1'b1;
                        end
                     end
                     rsp_load = 1'b1;
                  end
                  OP_CURSOR: begin
                     cursor_x_in = (32'(req_col) < COLS) ? req_col : COL_W'(COLS - 1);
                     cursor_y_in = (32'(req_row) < ROWS) ? req_row : ROW_W'(ROWS - 1);
                     rsp_load    = 1'b1;
                  end
                  OP_COLOR: begin
                     cur_fg_in = req_color;
                     rsp_load  = 1'b1;
                  end
                  OP_CLEAR: begin
                     state_in = ST_SWEEP;
                     mode_in  = MODE_CLEAR;
                     rsp_load = 1'b1;
                  end
                  OP_READ: begin
                     // Memory read goes out now; the answer is loaded in ST_READ.
                     read_hit_in = req_in_range;
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
               rd_idx_in = '0;
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            if (read_hit_ff) begin
               rsp_char_in = ram_rd_data.ch;
               rsp_fg_in   = ram_rd_data.fg;
               rsp_bg_in   = ram_rd_data.bg;
            end
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            // Read one entry per cycle; write it back in the next cycle.
            if ((mode_ff == MODE_SCROLL) && (32'(rd_idx_ff) < LAST_BASE)) begin
               ram_rd_addr = CELL_W'(32'(rd_idx_ff) + COLS);
            end else begin
               ram_rd_addr = rd_idx_ff;
            end
            wr_pend_in = 1'b1;
            if (32'(rd_idx_ff) == CELLS - 1) begin
               rd_idx_in = '0;
               state_in  = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Sweep write-back owns the write port whenever one is pending.
      if (wr_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_idx_ff;
         ram_wr_data.ch = ((mode_ff == MODE_SCROLL) && !wr_last_ff) ?
                          ram_rd_data.ch : 8'd0;
         ram_wr_data.fg = (mode_ff == MODE_INIT) ? 3'd0 : ram_rd_data.fg;
         ram_wr_data.bg = (mode_ff == MODE_SCROLL) ? ram_rd_data.bg : 3'd0;
      end

      // Result register: hold while stalled, drop when taken, load on finish.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      rsp_col_in = cursor_x_in;
      rsp_row_in = cursor_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         mode_ff      <= MODE_INIT;
         rd_idx_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         cur_fg_ff    <= FG_RESET;
         bg_color_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
         read_hit_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rd_idx_ff    <= rd_idx_in;
         wr_pend_ff   <= wr_pend_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         cur_fg_ff    <= cur_fg_in;
         bg_color_ff  <= bg_color_in;
         rsp_valid_ff <= rsp_valid_in;
         read_hit_ff  <= read_hit_in;
      end
      wr_idx_ff  <= wr_idx_in;
      wr_last_ff <= wr_last_in;
      if (rsp_load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_fg_ff   <= rsp_fg_in;
         rsp_bg_ff   <= rsp_bg_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_row_ff  <= rsp_row_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_fg    = rsp_fg_ff;
   assign rsp_cell_bg    = rsp_bg_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

`ifndef SYNTHESIS
   // A new result never overwrites one still waiting downstream.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> !rsp_stall)
      else $error("result register overwritten");

   // Sweep write-backs only happen inside a sweep.
   a_wb_in_sweep: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("grid write-back outside a sweep");

   // Cursor stays on the grid.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cursor_x_ff) < COLS) && (32'(cursor_y_ff) < ROWS))
      else $error("cursor off the grid");

   // A read cell item is answered straight after its ST_READ state.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_READ)) |=> ##1 rsp_valid_ff)
      else $error("read cell result late");
`endif

endmodule

// ----- tb/sv/tb_text_terminal_writer_unit.sv -----
// Self-checking testbench for text_terminal_writer_unit: directed and random
// terminal traffic checked against a shadow grid kept in this module.
// Depends on ttw_pkg and the text_terminal_writer_unit RTL only.
module tb_text_terminal_writer_unit;
   import ttw_pkg::*;

   localparam int COLS  = 53;
   localparam int ROWS  = 30;
   localparam int CELLS = COLS * ROWS;
   localparam int COL_W = $clog2(COLS);
   localparam int ROW_W = $clog2(ROWS);

   // Chance in a hundred that a side sits out a cycle
   localparam int IDLE_PCT = 28;
   // A clear or scroll holds the block for a full grid sweep; allow many times that
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 8;

   // Opcodes the block ignores; the package names only the used ones
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   // Register i sits at byte address 4*i
   localparam logic [2:0] BG_ADDR = {REG_BG_COLOR, 2'b00};

   typedef struct packed {
      logic [2:0]       op;
      logic [7:0]       ch;
      logic [2:0]       color;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } term_item_type;

   typedef struct packed {
      cell_type         cell_data;
      logic [COL_W-1:0] cur_col;
      logic [ROW_W-1:0] cur_row;
   } term_result_type;

   // Clock, reset and every block input start at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [2:0]       req_opcode = '0;
   logic [7:0]       req_char_code = '0;
   logic [2:0]       req_color = '0;
   logic [COL_W-1:0] req_col = '0;
   logic [ROW_W-1:0] req_row = '0;

   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_cell_char;
   logic [2:0]       rsp_cell_fg;
   logic [2:0]       rsp_cell_bg;
   logic [COL_W-1:0] rsp_cursor_col;
   logic [ROW_W-1:0] rsp_cursor_row;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the terminal: grid, cursor, colors
   logic [7:0] shadow_char [CELLS];
   logic [2:0] shadow_fg   [CELLS];
   logic [2:0] shadow_bg   [CELLS];
   int         cur_x, cur_y;
   logic [2:0] cur_fg;
   logic [2:0] bg_setting;

   term_result_type expected_q[$];

   bit idle_on = 1'b0;
   int fail_count = 0;
   int items_sent = 0;
   int chars_sent = 0;
   int results_checked = 0;
   int grid_sweeps = 0;
   int bg_writes = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   text_terminal_writer_unit #(.COLS(COLS), .ROWS(ROWS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_color      (req_color),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_fg    (rsp_cell_fg),
      .rsp_cell_bg    (rsp_cell_bg),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Shadow grid update
   // ---------------------------------------------------------------------

   // Move every row up one; the new bottom row loses its characters only,
   // its colors stay as they were.
   function automatic void shift_grid_up();
      for (int i = 0; i < CELLS - COLS; i++) begin
         shadow_char[i] = shadow_char[i + COLS];
         shadow_fg[i]   = shadow_fg[i + COLS];
         shadow_bg[i]   = shadow_bg[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++)
         shadow_char[i] = 8'd0;
      grid_sweeps++;
   endfunction

   // Step down one row, or scroll when already on the bottom row
   function automatic void line_feed();
      if (cur_y < ROWS - 1)
         cur_y++;
      else
         shift_grid_up();
   endfunction

   // Apply one item to the shadow and return the result it must produce
   function automatic term_result_type predict_item(input term_item_type it);
      term_result_type res;
      int idx;
      res = '0;
      case (it.op)
         OP_PUT: begin
            if (it.ch == CH_NEWLINE) begin
               line_feed();
            end else if (it.ch == CH_RETURN) begin
               cur_x = 0;
            end else if (it.ch == CH_BACKSPACE) begin
               // Backspace never erases; at column zero it wraps to the row above, if there is one
               if (cur_x == 0) begin
                  cur_x = COLS - 1;
                  if (cur_y > 0)
                     cur_y--;
               end else begin
                  cur_x--;
               end
            end else begin
               idx = cur_y * COLS + cur_x;
               shadow_char[idx] = it.ch;
               shadow_fg[idx]   = cur_fg;
               shadow_bg[idx]   = bg_setting;
               cur_x++;
               if (cur_x >= COLS) begin
                  line_feed();
                  cur_x = 0;
               end
            end
         end
         OP_CURSOR: begin
            // Out-of-range positions saturate at the last column / row
            cur_x = (it.col < COLS) ? int'(it.col) : COLS - 1;
            cur_y = (it.row < ROWS) ? int'(it.row) : ROWS - 1;
         end
         OP_COLOR: cur_fg = it.color;
         OP_CLEAR: begin
            // Foreground colors and the cursor survive a clear
            for (int i = 0; i < CELLS; i++) begin
               shadow_char[i] = 8'd0;
               shadow_bg[i]   = 3'd0;
            end
            grid_sweeps++;
         end
         OP_READ: begin
            if (it.col < COLS && it.row < ROWS) begin
               idx = int'(it.row) * COLS + int'(it.col);
               res.cell_data.ch = shadow_char[idx];
               res.cell_data.fg = shadow_fg[idx];
               res.cell_data.bg = shadow_bg[idx];
            end
         end
         default: ;
      endcase
      res.cur_col = COL_W'(cur_x);
      res.cur_row = ROW_W'(cur_y);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one item and hold it until taken; called at a rising edge and
   // returns at the edge that took it, with valid still high.
   task automatic send_item(input logic [2:0] op, input logic [7:0] ch,
                            input logic [2:0] color, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row);
      term_item_type it;
      it = '{op, ch, color, col, row};
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_char_code <= ch;
      req_color     <= color;
      req_col       <= col;
      req_row       <= row;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_item(it));
      items_sent++;
      if (op == OP_PUT)
         chars_sent++;
   endtask

   // Unused fields of each operation carry random values
   task automatic write_char(input logic [7:0] ch);
      send_item(OP_PUT, ch, 3'($urandom), COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic move_cursor(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      send_item(OP_CURSOR, 8'($urandom), 3'($urandom), col, row);
   endtask

   task automatic set_fg(input logic [2:0] color);
      send_item(OP_COLOR, 8'($urandom), color, COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic wipe_grid();
      send_item(OP_CLEAR, 8'($urandom), 3'($urandom), COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic probe_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      send_item(OP_READ, 8'($urandom), 3'($urandom), col, row);
   endtask

   // Drop valid, wait for every outstanding result, then let the block settle.
   // Ends at a rising edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the background color register while idle, then read it back
   task automatic program_background(input logic [2:0] value);
      logic [31:0] readback;
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BG_ADDR;
      // upper data bits are junk the register must drop
      csr_pwdata  <= {29'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // written at this edge; go straight into the read setup
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      bg_setting = value;
      bg_writes++;
      if (readback !== {29'd0, value}) begin
         $error("background_color readback: expected %0d, got %0d", value, readback);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, in-order checking, watchdog
   // ---------------------------------------------------------------------

   always @(posedge clock)
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Sample at the falling edge: what is seen here is what the next rising
   // edge takes, and nothing on this side changes in between.
   always @(negedge clock) begin : result_check
      term_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result arrived with nothing expected");
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("cell_char",  32'(want.cell_data.ch), 32'(rsp_cell_char));
            check_field("cell_fg",    32'(want.cell_data.fg), 32'(rsp_cell_fg));
            check_field("cell_bg",    32'(want.cell_data.bg), 32'(rsp_cell_bg));
            check_field("cursor_col", 32'(want.cur_col), 32'(rsp_cursor_col));
            check_field("cursor_row", 32'(want.cur_row), 32'(rsp_cursor_row));
            results_checked++;
         end
      end
   end

   // Count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Extreme character and color values stored and read back; reads off the grid
   task automatic test_cell_store();
      set_fg(3'd0);
      write_char(8'hFF);
      set_fg(FG_RESET);
      write_char(8'h00);              // a zero byte is an ordinary character
      probe_cell('0, '0);
      probe_cell(COL_W'(1), '0);
      probe_cell('1, '1);             // both coordinates out of range
      probe_cell(COL_W'(COLS), '0);   // column just past the edge
   endtask

   // Saturating cursor, wrap at the bottom-right cell, scroll on newline
   task automatic test_cursor_scroll();
      move_cursor('1, '1);
      write_char(8'h5A);              // lands in the last cell, wraps and scrolls
      probe_cell(COL_W'(COLS - 1), ROW_W'(ROWS - 2));
      write_char(CH_NEWLINE);         // bottom row: scroll again
      probe_cell(COL_W'(COLS - 1), ROW_W'(ROWS - 3));
   endtask

   // Backspace across a row boundary and at the origin, return, newline
   task automatic test_control_codes();
      write_char(CH_BACKSPACE);
      write_char(CH_BACKSPACE);
      write_char(CH_RETURN);
      write_char(CH_NEWLINE);
      move_cursor('0, '0);
      write_char(CH_BACKSPACE);       // row zero: column wraps, row stays
   endtask

   // Clear keeps foreground colors and the cursor
   task automatic test_clear();
      wipe_grid();
      probe_cell('0, '0);
      probe_cell(COL_W'(COLS - 1), ROW_W'(ROWS - 3));
   endtask

   task automatic test_spare_opcodes();
      send_item(OP_SPARE_FIRST, 8'($urandom), 3'($urandom), COL_W'($urandom),
                ROW_W'($urandom));
      send_item(OP_SPARE_LAST, 8'($urandom), 3'($urandom), COL_W'($urandom),
                ROW_W'($urandom));
   endtask

   // A line of text: mostly printable bytes, sometimes any byte, usually
   // closed by return and newline. Long lines wrap.
   task automatic write_text_line();
      int len;
      len = $urandom_range(1, 70);
      repeat (len) begin
         if ($urandom_range(99) < 90)
            write_char(8'($urandom_range(8'h20, 8'h7E)));
         else
            write_char(8'($urandom));
      end
      if ($urandom_range(99) < 85)
         write_char(CH_RETURN);
      if ($urandom_range(99) < 85)
         write_char(CH_NEWLINE);
   endtask

   task automatic random_single();
      int roll;
      roll = $urandom_range(99);
      if (roll < 28) begin
         write_char(8'($urandom));
      end else if (roll < 38) begin
         case ($urandom_range(2))
            0:       write_char(CH_NEWLINE);
            1:       write_char(CH_RETURN);
            default: write_char(CH_BACKSPACE);
         endcase
      end else if (roll < 52) begin
         move_cursor(COL_W'($urandom), ROW_W'($urandom));
      end else if (roll < 60) begin
         set_fg(3'($urandom));
      end else if (roll < 64) begin
         wipe_grid();
      end else if (roll < 90) begin
         // Mostly look where text was just written
         if ($urandom_range(99) < 70)
            probe_cell(COL_W'($urandom_range(COLS - 1)), ROW_W'(cur_y));
         else
            probe_cell(COL_W'($urandom), ROW_W'($urandom));
      end else begin
         send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 8'($urandom),
                   3'($urandom), COL_W'($urandom), ROW_W'($urandom));
      end
   endtask

   // Random traffic; halfway through, hold the sender until all results are in
   task automatic test_random_traffic(input int count, input bit with_idle);
      int stop_at;
      bit paused;
      stop_at = items_sent + count;
      paused = 1'b0;
      idle_on = with_idle;
      while (items_sent < stop_at) begin
         if (!paused && items_sent >= stop_at - count / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 40)
            write_text_line();
         else
            random_single();
      end
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         shadow_char[i] = 8'd0;
         shadow_fg[i]   = 3'd0;
         shadow_bg[i]   = 3'd0;
      end
      cur_x = 0;
      cur_y = 0;
      cur_fg = FG_RESET;
      bg_setting = 3'd0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part with idling on both sides and the brightest background
      idle_on = 1'b1;
      program_background(3'd7);
      test_cell_store();
      test_cursor_scroll();
      test_control_codes();
      test_clear();
      test_spare_opcodes();

      // Random part across several background settings; the middle phase
      // runs without any idling
      program_background(3'($urandom_range(1, 6)));
      test_random_traffic(520, 1'b1);
      program_background(3'd0);
      test_random_traffic(400, 1'b0);
      program_background(3'($urandom));
      test_random_traffic(530, 1'b1);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d results never arrived", expected_q.size());
         fail_count++;
      end

      $display("Covered %0d items (%0d put char), %0d results checked, %0d grid sweeps.",
               items_sent, chars_sent, results_checked, grid_sweeps);
      $display("Background color set %0d times; wrap, scroll, clear and saturation hit.",
               bg_writes);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
design/ttw_pkg.sv
design/ttw_grid_ram.sv
design/text_terminal_writer_unit.sv
tb/sv/tb_text_terminal_writer_unit.sv
